@@ design/mm_pkg.sv @@
// ----------------------------------------------------------------------------
// Matrix multiply package
// Shared widths, codes and the control/status types of the block.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int WORD_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int IDX_W       = 4;
  localparam int OP_W        = 2;
  localparam int DIM_W       = 5;
  localparam int DEF_MAX_DIM = 16;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic write_a;
    logic write_b;
    logic start;
    logic issue;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic last_term;
    logic pipe_busy;
    logic out_free;
  } ctl_sts_t;

endpackage

@@ design/mm_if.sv @@
// ----------------------------------------------------------------------------
// Matrix multiply channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mm_req_if;
  logic                                valid;
  logic                                ready;
  logic [mm_pkg::OP_W-1:0]             opcode;
  logic [mm_pkg::IDX_W-1:0]            row_index;
  logic [mm_pkg::IDX_W-1:0]            col_index;
  logic signed [mm_pkg::WORD_W-1:0]    element_value;

  modport source (output valid, opcode, row_index, col_index, element_value, input ready);
  modport sink   (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

interface mm_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [mm_pkg::IDX_W-1:0]            result_row;
  logic [mm_pkg::IDX_W-1:0]            result_col;
  logic signed [mm_pkg::WORD_W-1:0]    result_value;
  logic                                saturated;

  modport source (output valid, result_row, result_col, result_value, saturated, input ready);
  modport sink   (input valid, result_row, result_col, result_value, saturated, output ready);
endinterface

@@ design/mm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Matrix multiply controller
// Decodes accepted words and sequences the multiply-accumulate walk.
// ----------------------------------------------------------------------------
module mm_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [mm_pkg::OP_W-1:0] in_opcode,
  output logic                    in_ready,
  input  mm_pkg::ctl_sts_t        sts,
  output mm_pkg::ctl_cmd_t        cmd
);
  import mm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_opcode)
            OP_WRITE_A: cmd.write_a = 1'b1;
            OP_WRITE_B: cmd.write_b = 1'b1;
            OP_READ: begin
              cmd.start  = 1'b1;
              state_next = ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        cmd.issue = 1'b1;
        if (sts.last_term) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ design/mm_datapath.sv @@
// ----------------------------------------------------------------------------
// Matrix multiply datapath
// Element stores, one multiply-accumulate unit and the result register.
// ----------------------------------------------------------------------------
module mm_datapath #(
  parameter int MAX_DIM = mm_pkg::DEF_MAX_DIM
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mm_pkg::DIM_W-1:0]         cfg_wdata,
  input  logic [mm_pkg::IDX_W-1:0]         in_row,
  input  logic [mm_pkg::IDX_W-1:0]         in_col,
  input  logic signed [mm_pkg::WORD_W-1:0] in_value,
  input  mm_pkg::ctl_cmd_t                 cmd,
  output mm_pkg::ctl_sts_t                 sts,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mm_pkg::IDX_W-1:0]         out_row,
  output logic [mm_pkg::IDX_W-1:0]         out_col,
  output logic signed [mm_pkg::WORD_W-1:0] out_value,
  output logic                             out_sat
);
  import mm_pkg::*;

  localparam int IW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(MAX_DIM + 1);
  localparam int CW    = (KW > DIM_W) ? KW : DIM_W;
  localparam int MW    = (KW > IDX_W) ? KW + 1 : IDX_W + 1;
  localparam int PW    = 2 * WORD_W;
  localparam int ACC_W = PW + KW;
  localparam int TOP_LO = FRAC_W + WORD_W - 1;

  function automatic logic [IW-1:0] wrap_idx(input logic [IDX_W-1:0] v);
    logic [MW-1:0] t;
    t = MW'(v);
    for (int i = 0; i < 8; i++) begin
      if (t >= MW'(MAX_DIM)) begin
        t = t - MW'(MAX_DIM);
      end
    end
    return IW'(t);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) * AW'(MAX_DIM) + AW'(c);
  endfunction

  logic [DIM_W-1:0]         inner_dim;
  logic [CW-1:0]            dim_ext;
  logic [KW-1:0]            n_terms;
  logic [KW-1:0]            k;
  logic [IDX_W-1:0]         row_q;
  logic [IDX_W-1:0]         col_q;
  logic [WORD_W-1:0]        mem_a [DEPTH];
  logic [WORD_W-1:0]        mem_b [DEPTH];
  logic [WORD_W-1:0]        a_rd;
  logic [WORD_W-1:0]        b_rd;
  logic                     rd_valid;
  logic signed [PW-1:0]     prod;
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  acc;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            a_addr;
  logic [AW-1:0]            b_addr;
  logic                     fits;
  logic [WORD_W-1:0]        res;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_dim <= DIM_RESET;
    end else if (cfg_we) begin
      inner_dim <= cfg_wdata;
    end
  end

  always_comb begin
    dim_ext = CW'(inner_dim);
    if (dim_ext == '0) begin
      n_terms = KW'(1);
    end else if (dim_ext > CW'(MAX_DIM)) begin
      n_terms = KW'(MAX_DIM);
    end else begin
      n_terms = KW'(dim_ext);
    end
  end

  assign wr_addr = addr_of(wrap_idx(in_row), wrap_idx(in_col));
  assign a_addr  = addr_of(wrap_idx(row_q), IW'(k));
  assign b_addr  = addr_of(IW'(k), wrap_idx(col_q));

  always_ff @(posedge clk) begin
    if (cmd.write_a) begin
      mem_a[wr_addr] <= in_value;
    end
    if (cmd.issue) begin
      a_rd <= mem_a[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_b) begin
      mem_b[wr_addr] <= in_value;
    end
    if (cmd.issue) begin
      b_rd <= mem_b[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      row_q <= in_row;
      col_q <= in_col;
      k     <= '0;
    end else if (cmd.issue) begin
      k <= k + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= cmd.issue;
      prod_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(a_rd) * $signed(b_rd);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign fits = (&acc[ACC_W-1:TOP_LO]) | ~(|acc[ACC_W-1:TOP_LO]);

  always_comb begin
    if (fits) begin
      res = acc[TOP_LO:FRAC_W];
    end else if (acc[ACC_W-1]) begin
      res = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(WORD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_row   <= row_q;
      out_col   <= col_q;
      out_value <= res;
      out_sat   <= ~fits;
    end
  end

  assign sts.last_term = (k == n_terms - KW'(1));
  assign sts.pipe_busy = rd_valid | prod_valid;
  assign sts.out_free  = ~out_valid | out_ready;

endmodule

@@ design/matrix_multiply.sv @@
// ----------------------------------------------------------------------------
// Matrix multiply
// Holds matrices A and B in Q16.16 and returns single elements of A times B.
// ----------------------------------------------------------------------------
// A write word is stored when accepted and the next word is accepted in the cycle after.
// A read issues n terms, lets the pipeline drain, then loads the result register, where n
// is inner_dim held to 1..MAX_DIM and the multiply-accumulate unit walks one term a cycle.
// A finished result waits in the output register while the next word is taken.
// Reset is synchronous; it clears the control state and sets inner_dim to 16.
// Matrix entries are not cleared and must be written before they are read.
module matrix_multiply #(
  parameter int MAX_DIM = mm_pkg::DEF_MAX_DIM
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [mm_pkg::DIM_W-1:0] cfg_wdata,
  mm_req_if.sink                   req,
  mm_rsp_if.source                 rsp
);
  import mm_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  mm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_opcode (req.opcode),
    .in_ready  (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mm_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_row    (req.row_index),
    .in_col    (req.col_index),
    .in_value  (req.element_value),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_row   (rsp.result_row),
    .out_col   (rsp.result_col),
    .out_value (rsp.result_value),
    .out_sat   (rsp.saturated)
  );

endmodule

@@ sim/tb_matrix_multiply.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply testbench
// Writes elements of A and B through the request channel and reads elements of
// A times B back. A scoreboard class keeps its own copy of both stores and of
// inner_dim and predicts every product element at full precision, with the
// Q16.16 shift and the saturation flag. Each returned element is compared
// with the oldest prediction. Both channels idle in random bursts, and the
// response side holds off once for a long stretch to fill the block.
// ----------------------------------------------------------------------------
module tb_matrix_multiply;
  import mm_pkg::*;

  localparam int DIM           = DEF_MAX_DIM;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASE_WORDS   = 105;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic signed [127:0] SAT_HIGH = 128'sh7FFFFFFF;
  localparam logic signed [127:0] SAT_LOW  = -128'sh80000000;

  typedef struct {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [WORD_W-1:0] value;
    logic                     sat;
  } element_t;

  class element_tracker;
    logic signed [WORD_W-1:0] a_vals [DIM][DIM];
    logic signed [WORD_W-1:0] b_vals [DIM][DIM];
    logic [DIM_W-1:0]         inner_dim;
    element_t                 pending_products [$];
    int                       fail_count;
    int                       reads_checked;
    int                       saturations;

    function new();
      inner_dim     = DIM_RESET;
      fail_count    = 0;
      reads_checked = 0;
      saturations   = 0;
    endfunction

    task report_mismatch(string msg);
      if (fail_count < 40) begin
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      fail_count++;
    endtask

    function element_t product_element(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
      element_t                 e;
      logic signed [127:0]      acc;
      logic signed [127:0]      scaled;
      logic signed [63:0]       term;
      int                       n;
      n = (inner_dim == 0) ? 1 : ((inner_dim > DIM) ? DIM : int'(inner_dim));
      acc = '0;
      for (int k = 0; k < n; k++) begin
        term = a_vals[r][k] * b_vals[k][c];
        acc = acc + term;
      end
      scaled = acc >>> FRAC_W;
      e.row = r;
      e.col = c;
      if (scaled > SAT_HIGH) begin
        e.value = 32'sh7FFFFFFF;
        e.sat = 1'b1;
      end else if (scaled < SAT_LOW) begin
        e.value = 32'sh80000000;
        e.sat = 1'b1;
      end else begin
        e.value = scaled[WORD_W-1:0];
        e.sat = 1'b0;
      end
      return e;
    endfunction

    function void note_word(logic [OP_W-1:0] op, logic [IDX_W-1:0] r,
                            logic [IDX_W-1:0] c, logic signed [WORD_W-1:0] v);
      case (op)
        OP_WRITE_A: a_vals[r][c] = v;
        OP_WRITE_B: b_vals[r][c] = v;
        OP_READ:    pending_products = {pending_products, product_element(r, c)};
        default: ;
      endcase
    endfunction

    task check_result(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                      logic signed [WORD_W-1:0] v, logic s);
      element_t e;
      if (pending_products.size() == 0) begin
        report_mismatch($sformatf("unrequested result at (%0d,%0d)", r, c));
      end else begin
        e = pending_products.pop_front();
        reads_checked++;
        if (e.sat) begin
          saturations++;
        end
        if (r !== e.row) begin
          report_mismatch($sformatf("result_row %0d, predicted %0d", r, e.row));
        end
        if (c !== e.col) begin
          report_mismatch($sformatf("result_col %0d, predicted %0d", c, e.col));
        end
        if (v !== e.value) begin
          report_mismatch($sformatf("result_value %h at (%0d,%0d), predicted %h",
                                    v, e.row, e.col, e.value));
        end
        if (s !== e.sat) begin
          report_mismatch($sformatf("saturated %b at (%0d,%0d), predicted %b",
                                    s, e.row, e.col, e.sat));
        end
      end
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [DIM_W-1:0] cfg_wdata;

  mm_req_if req_ch ();
  mm_rsp_if rsp_ch ();

  element_tracker tracker = new();

  bit a_set [DIM][DIM];
  bit b_set [DIM][DIM];
  bit hold_request = 1'b0;
  bit calm = 1'b0;
  int words_sent = 0;

  matrix_multiply #(.MAX_DIM(DIM)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("Timeout with %0d reads still pending.", tracker.pending_products.size());
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      tracker.note_word(req_ch.opcode, req_ch.row_index, req_ch.col_index,
                        req_ch.element_value);
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      tracker.check_result(rsp_ch.result_row, rsp_ch.result_col, rsp_ch.result_value,
                           rsp_ch.saturated);
    end
  end

  initial begin : result_sink
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  function automatic logic [WORD_W-1:0] pick_value();
    logic [WORD_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
      4, 5:       v = $urandom;
      6: begin
        case ($urandom_range(0, 5))
          0:       v = 32'h7FFFFFFF;
          1:       v = 32'h80000000;
          2:       v = 32'hFFFFFFFF;
          3:       v = 32'h00010000;
          4:       v = 32'hFFFF0000;
          default: v = 32'h00000000;
        endcase
      end
      default:    v = $urandom_range(0, 32'h01FFFFFF) - 32'h01000000;
    endcase
    return v;
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic [WORD_W-1:0] v);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.row_index     <= r;
    req_ch.col_index     <= c;
    req_ch.element_value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (op != OP_UNUSED) begin
      words_sent++;
    end
    if (op == OP_WRITE_A) begin
      a_set[r][c] = 1'b1;
    end else if (op == OP_WRITE_B) begin
      b_set[r][c] = 1'b1;
    end
  endtask

  // Fills in any entry that the read would use before issuing the read itself.
  task automatic read_element(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
    int n;
    n = (tracker.inner_dim == 0) ? 1 :
        ((tracker.inner_dim > DIM) ? DIM : int'(tracker.inner_dim));
    for (int k = 0; k < n; k++) begin
      if (!a_set[r][k]) begin
        send_word(OP_WRITE_A, r, IDX_W'(k), pick_value());
      end
      if (!b_set[k][c]) begin
        send_word(OP_WRITE_B, IDX_W'(k), c, pick_value());
      end
    end
    send_word(OP_READ, r, c, $urandom);
  endtask

  task automatic set_inner_dim(input logic [DIM_W-1:0] dim);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= dim;
    @(posedge clk);
    tracker.inner_dim = dim;
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    int target;
    int sel;
    target = words_sent + count;
    while (words_sent < target) begin
      sel = $urandom_range(0, 19);
      if (sel < 12) begin
        read_element(IDX_W'($urandom_range(0, DIM - 1)),
                     IDX_W'($urandom_range(0, DIM - 1)));
      end else if (sel < 15) begin
        send_word(OP_WRITE_A, IDX_W'($urandom_range(0, DIM - 1)),
                  IDX_W'($urandom_range(0, DIM - 1)), pick_value());
      end else if (sel < 18) begin
        send_word(OP_WRITE_B, IDX_W'($urandom_range(0, DIM - 1)),
                  IDX_W'($urandom_range(0, DIM - 1)), pick_value());
      end else begin
        send_word(OP_UNUSED, IDX_W'($urandom_range(0, DIM - 1)),
                  IDX_W'($urandom_range(0, DIM - 1)), $urandom);
      end
    end
  endtask

  initial begin : stimulus
    logic [DIM_W-1:0] phase_dims [6];
    int               drain;
    phase_dims = '{5'd0, 5'd16, 5'd31, 5'd5, 5'd2, 5'd17};
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_wdata            <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.opcode        <= OP_WRITE_A;
    req_ch.row_index     <= '0;
    req_ch.col_index     <= '0;
    req_ch.element_value <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Single-term products so each extreme shows up alone in the result.
    set_inner_dim(5'd1);
    send_word(OP_WRITE_A, 15, 0, 32'h7FFFFFFF);
    send_word(OP_WRITE_B, 0, 15, 32'h7FFFFFFF);
    send_word(OP_READ, 15, 15, 32'h0);
    send_word(OP_WRITE_B, 0, 0, 32'h00010000);
    send_word(OP_READ, 15, 0, 32'h0);
    send_word(OP_WRITE_A, 0, 0, 32'h80000000);
    send_word(OP_READ, 0, 0, 32'h0);
    send_word(OP_READ, 0, 15, 32'h0);
    send_word(OP_WRITE_B, 0, 3, 32'h80000000);
    send_word(OP_READ, 0, 3, 32'h0);
    send_word(OP_WRITE_A, 7, 0, 32'hFFFF0000);
    send_word(OP_READ, 7, 0, 32'hFFFFFFFF);
    send_word(OP_WRITE_A, 7, 0, 32'hFFFFFFFF);
    send_word(OP_READ, 7, 0, 32'h0);
    send_word(OP_READ, 7, 15, 32'h0);
    send_word(OP_UNUSED, 15, 15, 32'hFFFFFFFF);
    send_word(OP_READ, 15, 15, 32'h0);
    send_word(OP_WRITE_A, 3, 0, 32'h0);
    send_word(OP_READ, 3, 0, 32'h0);

    for (int p = 0; p < 6; p++) begin
      set_inner_dim(phase_dims[p]);
      if (p == 1) begin
        hold_request = 1'b1;
      end
      if (p == 5) begin
        calm = 1'b1;
      end
      random_phase(PHASE_WORDS);
    end

    req_ch.valid <= 1'b0;
    drain = 0;
    while (tracker.pending_products.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.pending_products.size() != 0) begin
      tracker.report_mismatch($sformatf("%0d reads never answered",
                                        tracker.pending_products.size()));
    end

    $display("Sent %0d words and checked %0d product elements, %0d of them saturated.",
             words_sent, tracker.reads_checked, tracker.saturations);
    $display("inner_dim ran at 1, 0, 16, 31, 5, 2 and 17, with one long result stall.");
    if (tracker.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/mm_pkg.sv
design/mm_if.sv
design/mm_ctrl.sv
design/mm_datapath.sv
design/matrix_multiply.sv
sim/tb_matrix_multiply.sv
